// ===== hdl/bpe_pkg.sv =====
`default_nettype none
package bpe_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int COL_W       = $clog2(MAX_WIDTH) + 1;
  localparam int VW_W        = 12;
  localparam int CMP_W       = VW_W + 1;
  localparam int PADDR_W     = 5;
  localparam int CMDQ_DEPTH  = 2;
  localparam int OFQ_DEPTH   = 4;

  localparam logic [1:0] MODE_PAL = 2'd0;
  localparam logic [1:0] MODE_PIX = 2'd1;
  localparam logic [1:0] MODE_ROW = 2'd2;

  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;
  localparam logic [2:0] DEPTH_24 = 3'd5;
  localparam logic [2:0] DEPTH_32 = 3'd6;

  localparam logic [2:0] REG_DEPTH      = 3'd0;
  localparam logic [2:0] REG_FORMAT_565 = 3'd1;
  localparam logic [2:0] REG_COLOR_REQ  = 3'd2;
  localparam logic [2:0] REG_MULTICOLOR = 3'd3;
  localparam logic [2:0] REG_VIS_WIDTH  = 3'd4;

  localparam logic [1:0] CLS_WHITE   = 2'd0;
  localparam logic [1:0] CLS_COLORED = 2'd1;
  localparam logic [1:0] CLS_BLACK   = 2'd2;
  localparam logic [1:0] CLS_KEEP    = 2'd3;

  typedef enum logic [1:0] {
    K_PAL,
    K_IDX,
    K_DIR,
    K_ROW
  } kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] palette_index;
    logic [7:0] pal_blue;
    logic [7:0] pal_green;
    logic [7:0] pal_red;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rgb565;
    logic [1:0]  color_class;
    logic [10:0] column;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]      depth_select;
    logic            format_565;
    logic            color_req;
    logic            multicolor_panel;
    logic [VW_W-1:0] visible_width;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  arg;
    logic [15:0] color;
    logic        white;
    logic        colored;
  } cmd_t;

  typedef struct packed {
    logic [15:0] color;
    logic        white;
    logic        colored;
  } pal_word_t;

  function automatic logic color_on(input cfg_t c);
    return c.color_req && (c.depth_select != DEPTH_1);
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic is_whitish(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic on);
    logic [9:0] sum;
    sum = 10'(r) + 10'(g) + 10'(b);
    if (on) begin
      return (r > 8'h80) && (g > 8'h80) && (b > 8'h80);
    end
    return sum > 10'd384;
  endfunction

  function automatic logic is_colored(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return (r > 8'hF0) || ((g > 8'hF0) && (b > 8'hF0));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bpe_ram.sv =====
`default_nettype none
module bpe_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/bpe_cfg.sv =====
`default_nettype none
module bpe_cfg
  import bpe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DEPTH:      cfg_nxt.depth_select     = pwdata[2:0];
        REG_FORMAT_565: cfg_nxt.format_565       = pwdata[0];
        REG_COLOR_REQ:  cfg_nxt.color_req        = pwdata[0];
        REG_MULTICOLOR: cfg_nxt.multicolor_panel = pwdata[0];
        REG_VIS_WIDTH:  cfg_nxt.visible_width    = pwdata[VW_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_select     <= DEPTH_24;
      cfg_r.format_565       <= 1'b0;
      cfg_r.color_req        <= 1'b1;
      cfg_r.multicolor_panel <= 1'b0;
      cfg_r.visible_width    <= VW_W'(800);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEPTH:      prdata = 32'(cfg_r.depth_select);
      REG_FORMAT_565: prdata = 32'(cfg_r.format_565);
      REG_COLOR_REQ:  prdata = 32'(cfg_r.color_req);
      REG_MULTICOLOR: prdata = 32'(cfg_r.multicolor_panel);
      REG_VIS_WIDTH:  prdata = 32'(cfg_r.visible_width);
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/bpe_front.sv =====
`default_nettype none
module bpe_front
  import bpe_pkg::*;
(
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire cfg_t     cfg,
  input  wire logic     q_ready,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic keep;

  assign in_ready = q_ready;

  always_comb begin
    keep          = 1'b0;
    q_cmd.kind    = K_ROW;
    q_cmd.arg     = in_data.data_byte;
    q_cmd.color   = pack565(in_data.pal_red, in_data.pal_green, in_data.pal_blue);
    q_cmd.white   = is_whitish(in_data.pal_red, in_data.pal_green, in_data.pal_blue,
                               color_on(cfg));
    q_cmd.colored = is_colored(in_data.pal_red, in_data.pal_green, in_data.pal_blue);
    priority if (in_data.mode == MODE_PAL) begin
      keep       = 1'b1;
      q_cmd.kind = K_PAL;
      q_cmd.arg  = in_data.palette_index;
    end else if (in_data.mode == MODE_ROW) begin
      keep       = 1'b1;
      q_cmd.kind = K_ROW;
    end else if (in_data.mode == MODE_PIX && cfg.depth_select <= DEPTH_8) begin
      keep       = 1'b1;
      q_cmd.kind = K_IDX;
    end else if (in_data.mode == MODE_PIX && cfg.depth_select <= DEPTH_32) begin
      keep       = 1'b1;
      q_cmd.kind = K_DIR;
    end else begin
      keep = 1'b0;
    end
  end

  assign q_push = in_valid && q_ready && keep;

endmodule
`default_nettype wire

// ===== hdl/bpe_cmdq.sv =====
`default_nettype none
module bpe_cmdq
  import bpe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      push_ready,
  output logic      pop_valid,
  output cmd_t      pop_cmd,
  input  wire logic pop
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          ent_r [CMDQ_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign push_ready = cnt_r < CW'(CMDQ_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(CMDQ_DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(CMDQ_DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bpe_back.sv =====
`default_nettype none
module bpe_back
  import bpe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  localparam int OPW = $clog2(OFQ_DEPTH);
  localparam int OCW = $clog2(OFQ_DEPTH + 1);

  // command being worked on
  logic             cur_valid_r, cur_valid_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [7:0]       sh_r, sh_nxt;
  logic [2:0]       sub_r, sub_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [23:0]      holder_r, holder_nxt;
  logic [1:0]       held_r, held_nxt;

  // palette read stage
  logic             b_valid_r, b_valid_nxt;
  logic             b_ram_r, b_zero_r, b_white_r, b_colored_r, b_last_r;
  logic [15:0]      b_color_r;
  logic [10:0]      b_col_r;

  // result queue
  out_item_t        ofq_r [OFQ_DEPTH];
  logic [OPW-1:0]   owp_r, owp_nxt, orp_r, orp_nxt;
  logic [OCW-1:0]   ocnt_r, ocnt_nxt;

  logic [COL_W-1:0] lim;
  logic             credit, step, cur_done, last_sub, pix, emit, pix_last, complete;
  logic [2:0]       npix_m1;
  logic [1:0]       need_m1;
  logic [7:0]       pn, d, b0, b1, b2, r, g, b;
  logic [15:0]      dcolor;
  logic             pn_ok, pal_ok;
  logic             ram_we;
  logic [PAL_AW-1:0] ram_addr;
  pal_word_t        ram_wdata, ram_rdata;
  logic             o_push, o_pop;
  out_item_t        o_item;
  logic [15:0]      s_color;
  logic             s_white, s_colored, on;

  assign lim = (CMP_W'(cfg.visible_width) > CMP_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH)
                                                                  : COL_W'(cfg.visible_width);
  assign credit = (ocnt_r + OCW'(b_valid_r)) < OCW'(OFQ_DEPTH);
  assign d  = cur_r.arg;
  assign b0 = holder_r[7:0];
  assign b1 = holder_r[15:8];
  assign b2 = holder_r[23:16];

  always_comb begin
    unique case (cfg.depth_select)
      DEPTH_1: begin
        npix_m1 = 3'd7;
        pn      = {7'd0, sh_r[7]};
        sh_nxt  = {sh_r[6:0], 1'b0};
      end
      DEPTH_2: begin
        npix_m1 = 3'd3;
        pn      = {6'd0, sh_r[7:6]};
        sh_nxt  = {sh_r[5:0], 2'b0};
      end
      DEPTH_4: begin
        npix_m1 = 3'd1;
        pn      = {4'd0, sh_r[7:4]};
        sh_nxt  = {sh_r[3:0], 4'b0};
      end
      default: begin
        npix_m1 = 3'd0;
        pn      = sh_r;
        sh_nxt  = 8'd0;
      end
    endcase
  end

  always_comb begin
    unique case (cfg.depth_select)
      DEPTH_16: need_m1 = 2'd1;
      DEPTH_24: need_m1 = 2'd2;
      default:  need_m1 = 2'd3;
    endcase
  end

  // direct pixel conversion
  always_comb begin
    if (cfg.depth_select == DEPTH_16) begin
      b = {b0[4:0], 3'b0};
      if (cfg.format_565) begin
        g      = {d[2:0], b0[7:5], 2'b0};
        r      = {d[7:3], 3'b0};
        dcolor = {d, b0};
      end else begin
        g      = {d[1:0], b0[7:5], 3'b0};
        r      = {d[6:2], 3'b0};
        dcolor = pack565(r, g, b);
      end
    end else begin
      b      = b0;
      g      = b1;
      r      = (cfg.depth_select == DEPTH_24) ? d : b2;
      dcolor = pack565(r, g, b);
    end
  end

  assign complete = held_r >= need_m1;
  assign last_sub = sub_r == npix_m1;
  assign step     = cur_valid_r && (((cur_r.kind != K_IDX) && (cur_r.kind != K_DIR)) || credit);
  assign cur_done = step && ((cur_r.kind != K_IDX) || last_sub);
  assign q_pop    = q_valid && (!cur_valid_r || cur_done);
  assign pix      = step && ((cur_r.kind == K_IDX) || ((cur_r.kind == K_DIR) && complete));
  assign emit     = pix && (col_r < lim);
  assign pix_last = (cur_r.kind == K_DIR) || last_sub || (COL_W'(col_r + 1'b1) == lim);
  assign pn_ok    = {1'b0, pn} < 9'(PAL_ENTRIES);
  assign pal_ok   = {1'b0, cur_r.arg} < 9'(PAL_ENTRIES);

  assign ram_we    = step && (cur_r.kind == K_PAL) && pal_ok;
  assign ram_addr  = (cur_r.kind == K_PAL) ? cur_r.arg[PAL_AW-1:0] : pn[PAL_AW-1:0];
  assign ram_wdata = '{color: cur_r.color, white: cur_r.white, colored: cur_r.colored};

  bpe_ram #(
    .WIDTH ($bits(pal_word_t)),
    .DEPTH (PAL_ENTRIES)
  ) u_pal (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    sub_nxt       = sub_r;
    col_nxt       = col_r;
    holder_nxt    = holder_r;
    held_nxt      = held_r;
    b_valid_nxt   = emit;
    if (step) begin
      unique case (cur_r.kind)
        K_ROW: begin
          col_nxt    = '0;
          holder_nxt = '0;
          held_nxt   = '0;
        end
        K_DIR: begin
          if (complete) begin
            holder_nxt = '0;
            held_nxt   = '0;
          end else begin
            unique case (held_r)
              2'd0:    holder_nxt = {holder_r[23:8], d};
              2'd1:    holder_nxt = {holder_r[23:16], d, holder_r[7:0]};
              2'd2:    holder_nxt = {d, holder_r[15:0]};
              default: holder_nxt = holder_r;
            endcase
            held_nxt = 2'(held_r + 1'b1);
          end
        end
        K_IDX: begin
          sub_nxt = 3'(sub_r + 1'b1);
        end
        default: begin
          col_nxt = col_r;
        end
      endcase
      if (emit) begin
        col_nxt = COL_W'(col_r + 1'b1);
      end
    end
    if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_cmd;
      sub_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sub_r       <= '0;
      col_r       <= '0;
      holder_r    <= '0;
      held_r      <= '0;
      b_valid_r   <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      sub_r       <= sub_nxt;
      col_r       <= col_nxt;
      holder_r    <= holder_nxt;
      held_r      <= held_nxt;
      b_valid_r   <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (q_pop) begin
      sh_r <= q_cmd.arg;
    end else if (step) begin
      sh_r <= sh_nxt;
    end
    b_ram_r     <= cur_r.kind == K_IDX;
    b_zero_r    <= !pn_ok;
    b_color_r   <= dcolor;
    b_white_r   <= is_whitish(r, g, b, color_on(cfg));
    b_colored_r <= is_colored(r, g, b);
    b_col_r     <= 11'(col_r);
    b_last_r    <= pix_last;
  end

  // classification on the way into the result queue
  assign on = color_on(cfg);

  always_comb begin
    if (b_ram_r) begin
      s_color   = b_zero_r ? 16'd0 : ram_rdata.color;
      s_white   = !b_zero_r && ram_rdata.white;
      s_colored = !b_zero_r && ram_rdata.colored;
    end else begin
      s_color   = b_color_r;
      s_white   = b_white_r;
      s_colored = b_colored_r;
    end
    o_item.rgb565 = s_color;
    o_item.column = b_col_r;
    o_item.last   = b_last_r;
    priority if (on && cfg.multicolor_panel) begin
      o_item.color_class = CLS_KEEP;
    end else if (s_white) begin
      o_item.color_class = CLS_WHITE;
    end else if (s_colored && on) begin
      o_item.color_class = CLS_COLORED;
    end else begin
      o_item.color_class = CLS_BLACK;
    end
  end

  assign o_push    = b_valid_r;
  assign o_pop     = out_valid && out_ready;
  assign out_valid = ocnt_r != '0;
  assign out_data  = ofq_r[orp_r];

  always_comb begin
    owp_nxt  = o_push ? OPW'(owp_r + 1'b1) : owp_r;
    orp_nxt  = o_pop ? OPW'(orp_r + 1'b1) : orp_r;
    ocnt_nxt = ocnt_r;
    if (o_push && !o_pop) begin
      ocnt_nxt = OCW'(ocnt_r + 1'b1);
    end else if (o_pop && !o_push) begin
      ocnt_nxt = OCW'(ocnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      ofq_r[owp_r] <= o_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bmp_pixel_to_epaper_color.sv =====
// path: command queue, current command, palette read stage, result queue
// throughput: one result per cycle while the result queue has room; an indexed
// byte yields 8/bpp pixels, one palette ram read each; the input takes a new
// item each cycle while the 2-entry command queue has room
// reset: synchronous active-low rst_n restores register defaults, empties the
// queues, clears column and byte holder; the palette ram is not cleared
`default_nettype none
module bmp_pixel_to_epaper_color
  import bpe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t cfg;
  logic q_push, q_ready, q_valid, q_pop;
  cmd_t q_in, q_out;

  bpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpe_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  bpe_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_out),
    .pop        (q_pop)
  );

  bpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/bpe_checker.sv =====
`default_nettype none
module bpe_checker
  import bpe_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data,
  input wire logic      pready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind bmp_pixel_to_epaper_color bpe_checker u_bpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
`default_nettype wire
